FILE: rtl/rsd_pkg.sv
`timescale 1ns / 1ps

package rsd_pkg;

    // Decoder phases
    localparam logic [2:0] PH_OPCODE = 3'd0;
    localparam logic [2:0] PH_SCOUNT = 3'd1;
    localparam logic [2:0] PH_RUNPIX = 3'd2;
    localparam logic [2:0] PH_WLO    = 3'd3;
    localparam logic [2:0] PH_WHI    = 3'd4;
    localparam logic [2:0] PH_DUMP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // Command codes on the result channel
    localparam logic [1:0] CMD_LITERAL = 2'd0;
    localparam logic [1:0] CMD_FILL    = 2'd1;
    localparam logic [1:0] CMD_SKIP    = 2'd2;
    localparam logic [1:0] CMD_END     = 2'd3;

    // Opcode byte values
    localparam logic [7:0] OP_SHORT_RUN = 8'h00;
    localparam logic [7:0] OP_LONG      = 8'h80;

    // Largest frame the pixel writer takes; frame sizes saturate here.
    localparam logic [16:0] MAX_FRAME_PIXELS = 17'h10000;
    localparam logic [16:0] FRAME_PIXELS_RESET = 17'd64000;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [14:0] length;
        logic [16:0] position;
        logic [1:0]  command;
    } rsd_result_t;

endpackage

FILE: rtl/run_skip_dump_rle_decoder.sv
`timescale 1ns / 1ps

// Channel  | Direction | Contents
// ---------+-----------+------------------------------------------------------------
// s_       | in        | one compressed stream byte per transaction, frame start flag
// m_       | out       | one pixel-writer command per transaction (literal/fill/skip/end)
// cfg_     | in        | frame size register write
//
// Every input transaction is decoded in the cycle it is accepted; its command, if any,
// is registered into the output register, or the skid register if the output stalls.
// The rate is one byte per clock while s_tready is high, set by the single decode stage.
// Reset (aresetn low, synchronous) clears the decoder and sets the frame size to
// 64000; bytes before the first frame start are dropped. When m_tready is low,
// a second command parks in the skid register and s_tready drops until it drains.
module run_skip_dump_rle_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [0:0]  s_tuser,   // [0] frame_start
    // Command stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] position, [31:17] length, [39:32] pixel_value
    output logic [1:0]  m_tuser,   // [1:0] command
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    logic                 accept;
    logic                 res_valid;
    rsd_pkg::rsd_result_t res;
    rsd_pkg::rsd_result_t m_res;
    logic [16:0]          frame_pixels_reg;

    // The frame size is sampled by the decoder only at a frame start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= rsd_pkg::FRAME_PIXELS_RESET;
        end else if (cfg_wr_en) begin
            frame_pixels_reg <= cfg_wr_data;
        end
    end

    assign accept = s_tvalid && s_tready;

    rsd_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (accept),
        .in_byte      (s_tdata),
        .in_start     (s_tuser[0]),
        .frame_pixels (frame_pixels_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Only accepted bytes that produce a command are pushed to the output side.
    rsd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tdata = {m_res.pixel_value, m_res.length, m_res.position};
    assign m_tuser = m_res.command;

endmodule

FILE: rtl/rsd_decode.sv
`timescale 1ns / 1ps

module rsd_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_start,
    input  logic [16:0]          frame_pixels,
    output logic                 res_valid,
    output rsd_pkg::rsd_result_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [14:0] pending_reg, pending_next;
    logic [7:0]  wlo_reg, wlo_next;
    logic [16:0] remain_reg, remain_next;
    logic [16:0] wpos_reg, wpos_next;

    // State as seen after an optional frame start
    logic [2:0]  eff_phase;
    logic [14:0] eff_pending;
    logic [7:0]  eff_wlo;
    logic [16:0] eff_remain;
    logic [16:0] eff_wpos;
    logic [16:0] start_remain;

    // Shared clip and advance path
    logic        adv_en;
    logic [14:0] clip_req;
    logic [14:0] clip_len;
    logic [16:0] adv_remain;
    logic [15:0] word;

    assign start_remain = (frame_pixels < rsd_pkg::MAX_FRAME_PIXELS) ?
                          frame_pixels : rsd_pkg::MAX_FRAME_PIXELS;
    assign word = {in_byte, eff_wlo};

    always_comb begin
        if (in_start) begin
            eff_remain  = start_remain;
            eff_wpos    = '0;
            eff_pending = '0;
            eff_wlo     = '0;
            eff_phase   = (start_remain == '0) ? rsd_pkg::PH_DONE : rsd_pkg::PH_OPCODE;
        end else begin
            eff_remain  = remain_reg;
            eff_wpos    = wpos_reg;
            eff_pending = pending_reg;
            eff_wlo     = wlo_reg;
            eff_phase   = phase_reg;
        end
    end

    assign clip_len   = ({2'b00, clip_req} < eff_remain) ? clip_req : eff_remain[14:0];
    assign adv_remain = eff_remain - {2'b00, clip_len};

    always_comb begin
        phase_next   = eff_phase;
        pending_next = eff_pending;
        wlo_next     = eff_wlo;
        remain_next  = eff_remain;
        wpos_next    = eff_wpos;
        adv_en       = 1'b0;
        clip_req     = '0;
        res_valid    = 1'b0;
        res          = '0;
        res.position = eff_wpos;

        if (eff_remain != '0 && eff_phase < rsd_pkg::PH_DONE) begin
            unique case (eff_phase)
                rsd_pkg::PH_OPCODE: begin
                    if (in_byte == rsd_pkg::OP_SHORT_RUN) begin
                        phase_next = rsd_pkg::PH_SCOUNT;
                    end else if (in_byte < rsd_pkg::OP_LONG) begin
                        pending_next = {7'd0, in_byte};
                        phase_next   = rsd_pkg::PH_DUMP;
                    end else if (in_byte == rsd_pkg::OP_LONG) begin
                        phase_next = rsd_pkg::PH_WLO;
                    end else begin
                        // Short skip
                        clip_req    = {8'd0, in_byte[6:0]};
                        adv_en      = 1'b1;
                        phase_next  = rsd_pkg::PH_OPCODE;
                        res.command = rsd_pkg::CMD_SKIP;
                        res.length  = clip_len;
                        res_valid   = (clip_len != '0);
                    end
                end
                rsd_pkg::PH_SCOUNT: begin
                    pending_next = {7'd0, in_byte};
                    phase_next   = rsd_pkg::PH_RUNPIX;
                end
                rsd_pkg::PH_RUNPIX: begin
                    clip_req        = eff_pending;
                    adv_en          = 1'b1;
                    pending_next    = '0;
                    phase_next      = rsd_pkg::PH_OPCODE;
                    res.command     = rsd_pkg::CMD_FILL;
                    res.length      = clip_len;
                    res.pixel_value = in_byte;
                    res_valid       = (clip_len != '0);
                end
                rsd_pkg::PH_WLO: begin
                    wlo_next   = in_byte;
                    phase_next = rsd_pkg::PH_WHI;
                end
                rsd_pkg::PH_WHI: begin
                    if (word == '0) begin
                        // End-of-frame marker
                        res.command = rsd_pkg::CMD_END;
                        res_valid   = 1'b1;
                        phase_next  = rsd_pkg::PH_DONE;
                    end else if (!word[15]) begin
                        // Long skip
                        clip_req    = word[14:0];
                        adv_en      = 1'b1;
                        phase_next  = rsd_pkg::PH_OPCODE;
                        res.command = rsd_pkg::CMD_SKIP;
                        res.length  = clip_len;
                        res_valid   = (clip_len != '0);
                    end else if (word[14]) begin
                        pending_next = {1'b0, word[13:0]};
                        phase_next   = rsd_pkg::PH_RUNPIX;
                    end else begin
                        pending_next = {1'b0, word[13:0]};
                        phase_next   = (word[13:0] == '0) ? rsd_pkg::PH_OPCODE :
                                                            rsd_pkg::PH_DUMP;
                    end
                end
                rsd_pkg::PH_DUMP: begin
                    clip_req        = 15'd1;
                    adv_en          = 1'b1;
                    pending_next    = eff_pending - 15'd1;
                    phase_next      = (eff_pending == 15'd1) ? rsd_pkg::PH_OPCODE :
                                                               rsd_pkg::PH_DUMP;
                    res.command     = rsd_pkg::CMD_LITERAL;
                    res.length      = 15'd1;
                    res.pixel_value = in_byte;
                    res_valid       = 1'b1;
                end
                default: begin
                end
            endcase

            if (adv_en) begin
                wpos_next   = eff_wpos + {2'b00, clip_len};
                remain_next = adv_remain;
                if (adv_remain == '0) begin
                    phase_next = rsd_pkg::PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= rsd_pkg::PH_OPCODE;
            pending_reg <= '0;
            wlo_reg     <= '0;
            remain_reg  <= '0;
            wpos_reg    <= '0;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            wlo_reg     <= wlo_next;
            remain_reg  <= remain_next;
            wpos_reg    <= wpos_next;
        end
    end

endmodule

FILE: rtl/rsd_out_buf.sv
`timescale 1ns / 1ps

module rsd_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsd_pkg::rsd_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsd_pkg::rsd_result_t out_data
);

    logic                 out_valid_reg;
    rsd_pkg::rsd_result_t out_data_reg;
    logic                 skid_valid_reg;
    rsd_pkg::rsd_result_t skid_data_reg;
    logic                 out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

endmodule
